@@ rtl/source_enable_gain_ramp_assert.svh @@
// assertion macros for the source enable gain ramp block
`ifndef SOURCE_ENABLE_GAIN_RAMP_ASSERT_SVH
`define SOURCE_ENABLE_GAIN_RAMP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define SEGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication, checked out of reset
`define SEGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SEGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SEGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/segr_pkg.sv @@
// shared types and codes for the source enable gain ramp block
`default_nettype none

package segr_pkg;

    // item operation codes
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FADE_NORMAL     = 2'd0;
    localparam t_cfg_idx CFG_FADE_SOUNDSCAPE = 2'd1;
    localparam t_cfg_idx CFG_IS_SOUNDSCAPE   = 2'd2;

    // reported gain format
    localparam int GAIN_OUT_BITS = 17;
    localparam logic [GAIN_OUT_BITS-1:0] GAIN_OUT_UNITY = 17'h10000;

    // reset value of both ramp lengths
    localparam int FADE_FRAMES_RESET = 2400;

endpackage

`default_nettype wire

@@ rtl/source_enable_gain_ramp.sv @@
// click-free enable and mute fader for one audio source, serial datapath
`default_nettype none

// channel   direction  handshake                 payload
// in        sink       i_in_valid / o_in_stall   op, enable, immediate, frames
// out       source     o_out_valid / i_out_stall gain, active, ramp_left
// cfg       sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// a query word that advances a running ramp runs the diff, clip, multiply, accumulate,
// remainder and last steps before the output; one with no frames to advance goes from
// diff straight to the output; a set word that starts a ramp adds the magnitude,
// divide and commit steps; an immediate or unchanged set word ends right after decode
// every arithmetic step runs through one shared add/subtract unit, also the serial
// multiply (one bit of the elapsed count per cycle) and the restoring divide
// synchronous active-low reset; fader, config and output state clear at once, no sweep
// the input stalls during reset and while a word is in work; a finished result waits
// in the output register, so the next word may be taken while the result is stalled

module source_enable_gain_ramp #(
    parameter int RAMP_BITS      = 24,
    parameter int FRAME_BITS     = 48,
    parameter int GAIN_FRAC_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire segr_pkg::t_cfg_idx                i_cfg_idx,
    input  wire logic [RAMP_BITS-1:0]              i_cfg_data,
    // input words
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_op,
    input  wire logic                              i_enable,
    input  wire logic                              i_immediate,
    input  wire logic [FRAME_BITS-1:0]             i_transport_frame,
    input  wire logic [FRAME_BITS-1:0]             i_query_frame,
    // result words
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [segr_pkg::GAIN_OUT_BITS-1:0]     o_gain,
    output logic                                   o_active,
    output logic [RAMP_BITS-1:0]                   o_ramp_left
);

    import segr_pkg::*;

`include "source_enable_gain_ramp_assert.svh"

    // gain word: sign, one integer bit, fraction
    localparam int GW = GAIN_FRAC_BITS + 2;
    // shared unit width covers frame differences, gain sums and the divide remainder
    localparam int W0 = (FRAME_BITS + 1 > GW + 1) ? FRAME_BITS + 1 : GW + 1;
    localparam int W  = (W0 > RAMP_BITS + 2) ? W0 : RAMP_BITS + 2;
    // iteration counter covers the multiply and the divide
    localparam int MAXN = (RAMP_BITS > GAIN_FRAC_BITS + 1) ? RAMP_BITS : GAIN_FRAC_BITS + 1;
    localparam int CW   = $clog2(MAXN);

    localparam logic [GW-1:0] GAIN_ONE = {2'b01, {GAIN_FRAC_BITS{1'b0}}};
    // render threshold, about 0.0001 of unity
    localparam logic [GW-1:0] ACTIVE_THRESH =
        GW'((64'd1 << GAIN_FRAC_BITS) / 64'd10000);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,   // decode the word, fix up the first frame
        S_DIFF,   // frame minus last frame
        S_CLIP,   // limit elapsed frames to the frames remaining
        S_MUL,    // step magnitude times elapsed, one bit per cycle
        S_ACC,    // apply the delta to the gain
        S_REM,    // frames remaining minus elapsed
        S_LAST,   // last frame plus elapsed, snap at ramp end
        S_MAG,    // magnitude of target minus current gain
        S_DIV,    // restoring divide by the ramp length
        S_FIN,    // commit the new ramp
        S_OUT     // hand the result to the output register
    } t_state;

    t_state r_state;

    // configuration
    logic [RAMP_BITS-1:0]      r_fade_normal;
    logic [RAMP_BITS-1:0]      r_fade_soundscape;
    logic                      r_is_soundscape;

    // fader state
    logic                      r_en;
    logic [GW-1:0]             r_gain;
    logic                      r_tgt;
    logic [GAIN_FRAC_BITS:0]   r_step_mag;
    logic                      r_step_neg;
    logic [RAMP_BITS-1:0]      r_rem;
    logic [FRAME_BITS-1:0]     r_last;

    // captured word
    logic                      r_op;
    logic                      r_enreq;
    logic                      r_imm;
    logic [FRAME_BITS-1:0]     r_t;
    logic [FRAME_BITS-1:0]     r_q;

    // working registers
    logic [GW-1:0]             r_acc;    // product, then dividend and quotient
    logic [RAMP_BITS-1:0]      r_drem;   // divide remainder
    logic [RAMP_BITS-1:0]      r_mlt;    // multiplier bits, msb first
    logic [RAMP_BITS-1:0]      r_elap;
    logic [FRAME_BITS-1:0]     r_diff;
    logic [CW-1:0]             r_cnt;

    logic [RAMP_BITS-1:0]      ramp_len;
    logic [FRAME_BITS-1:0]     adv_frame;
    logic [GW-1:0]             tgt_val;
    logic [GW-1:0]             cur;
    logic                      act;

    logic [W-1:0]              alu_a;
    logic [W-1:0]              alu_b;
    logic                      alu_sub;
    logic [W:0]                alu_sum;
    logic [W-1:0]              alu_res;
    logic                      alu_borrow;

    logic                      in_take;
    logic                      out_free;
    logic                      frame_le;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);

    // a zero length register counts as one frame
    always_comb begin
        ramp_len = r_is_soundscape ? r_fade_soundscape : r_fade_normal;
        if (ramp_len == '0) begin
            ramp_len = RAMP_BITS'(1);
        end
    end

    assign adv_frame = (r_op == OP_QUERY) ? r_q : r_t;
    assign tgt_val   = r_tgt ? GAIN_ONE : '0;

    // clamp to [0, unity]
    always_comb begin
        if (r_gain[GW-1]) begin
            cur = '0;
        end else if (r_gain[GAIN_FRAC_BITS] && (|r_gain[GAIN_FRAC_BITS-1:0])) begin
            cur = GAIN_ONE;
        end else begin
            cur = r_gain;
        end
    end

    assign act = r_en || r_tgt || (r_rem != '0) ||
                 ($signed(r_gain) > $signed(ACTIVE_THRESH));

    // shared add/subtract unit, operands chosen by the sequencer
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_DIFF: begin
                alu_a   = W'(adv_frame);
                alu_b   = W'(r_last);
                alu_sub = 1'b1;
            end
            S_CLIP: begin
                alu_a   = W'(r_rem);
                alu_b   = W'(r_diff);
                alu_sub = 1'b1;
            end
            S_MUL: begin
                alu_a   = W'({r_acc[GW-2:0], 1'b0});
                alu_b   = r_mlt[RAMP_BITS-1] ? W'(r_step_mag) : '0;
            end
            S_ACC: begin
                alu_a   = {{(W-GW){r_gain[GW-1]}}, r_gain};
                alu_b   = W'(r_acc);
                alu_sub = r_step_neg;
            end
            S_REM: begin
                alu_a   = W'(r_rem);
                alu_b   = W'(r_elap);
                alu_sub = 1'b1;
            end
            S_LAST: begin
                alu_a   = W'(r_last);
                alu_b   = W'(r_elap);
            end
            S_MAG: begin
                alu_a   = W'(GAIN_ONE);
                alu_b   = W'(cur);
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = W'({r_drem, r_acc[GAIN_FRAC_BITS]});
                alu_b   = W'(ramp_len);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} +
                        (W+1)'(alu_sub);
    assign alu_res    = alu_sum[W-1:0];
    assign alu_borrow = alu_sub && !alu_sum[W];
    // frame at or before the last frame
    assign frame_le   = alu_borrow || (alu_res[FRAME_BITS-1:0] == '0);

    // sequencer, fader state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_fade_normal     <= RAMP_BITS'(FADE_FRAMES_RESET);
            r_fade_soundscape <= RAMP_BITS'(FADE_FRAMES_RESET);
            r_is_soundscape   <= 1'b0;
            r_en              <= 1'b0;
            r_gain            <= '0;
            r_tgt             <= 1'b0;
            r_step_mag        <= '0;
            r_step_neg        <= 1'b0;
            r_rem             <= '0;
            r_last            <= '0;
            o_out_valid       <= 1'b0;
            o_gain            <= '0;
            o_active          <= 1'b0;
            o_ramp_left       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FADE_NORMAL:     r_fade_normal     <= i_cfg_data;
                    CFG_FADE_SOUNDSCAPE: r_fade_soundscape <= i_cfg_data;
                    CFG_IS_SOUNDSCAPE:   r_is_soundscape   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // a word handed over in S_OUT refills the register in the same cycle
            if (o_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_op == OP_SET && r_imm) begin
                        // jump straight to the target
                        r_en       <= r_enreq;
                        r_tgt      <= r_enreq;
                        r_gain     <= r_enreq ? GAIN_ONE : '0;
                        r_step_mag <= '0;
                        r_step_neg <= 1'b0;
                        r_rem      <= '0;
                        r_last     <= r_t;
                        r_state    <= S_OUT;
                    end else if (r_op == OP_SET && r_en == r_enreq && r_tgt == r_enreq) begin
                        r_state <= S_OUT;
                    end else begin
                        // first word after reset picks up the transport position
                        if (r_last == '0 && r_t != '0) begin
                            r_last <= r_t;
                        end
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    if (frame_le || r_rem == '0) begin
                        if (r_rem == '0) begin
                            r_gain <= tgt_val;
                        end
                        if (!frame_le) begin
                            r_last <= adv_frame;
                        end
                        r_state <= (r_op == OP_QUERY) ? S_OUT : S_MAG;
                    end else begin
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_gain  <= alu_res[GW-1:0];
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_rem   <= alu_res[RAMP_BITS-1:0];
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    r_last <= alu_res[FRAME_BITS-1:0];
                    // ramp end snaps to the target
                    if (r_rem == '0) begin
                        r_gain     <= tgt_val;
                        r_step_mag <= '0;
                        r_step_neg <= 1'b0;
                    end
                    r_state <= (r_op == OP_QUERY) ? S_OUT : S_MAG;
                end
                S_MAG: begin
                    r_gain  <= cur;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_step_mag <= r_acc[GAIN_FRAC_BITS:0];
                    r_step_neg <= !r_enreq;
                    r_en       <= r_enreq;
                    r_tgt      <= r_enreq;
                    r_rem      <= ramp_len;
                    r_last     <= r_t;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        o_gain      <= cur[GAIN_FRAC_BITS -: GAIN_OUT_BITS];
                        o_active    <= act;
                        o_ramp_left <= r_rem;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // captured word and iteration registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op    <= i_op;
            r_enreq <= i_enable;
            r_imm   <= i_immediate;
            r_t     <= i_transport_frame;
            r_q     <= i_query_frame;
        end
        unique case (r_state)
            S_DIFF: begin
                r_diff <= alu_res[FRAME_BITS-1:0];
            end
            S_CLIP: begin
                // elapsed is the smaller of the frame gap and the frames left
                if (alu_borrow) begin
                    r_elap <= r_rem;
                    r_mlt  <= r_rem;
                end else begin
                    r_elap <= r_diff[RAMP_BITS-1:0];
                    r_mlt  <= r_diff[RAMP_BITS-1:0];
                end
                r_acc <= '0;
                r_cnt <= CW'(RAMP_BITS - 1);
            end
            S_MUL: begin
                r_acc <= alu_res[GW-1:0];
                r_mlt <= {r_mlt[RAMP_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            S_MAG: begin
                // towards unity: one minus gain, towards silence: the gain itself
                r_acc  <= r_enreq ? alu_res[GW-1:0] : cur;
                r_drem <= '0;
                r_cnt  <= CW'(GAIN_FRAC_BITS);
            end
            S_DIV: begin
                // a failed trial leaves the shifted remainder below the length
                if (alu_borrow) begin
                    r_drem <= {r_drem[RAMP_BITS-2:0], r_acc[GAIN_FRAC_BITS]};
                end else begin
                    r_drem <= alu_res[RAMP_BITS-1:0];
                end
                r_acc <= GW'({r_acc[GAIN_FRAC_BITS-1:0], !alu_borrow});
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    `SEGR_ASSERT_NXT(a_take_starts_prep, i_clk, i_rst_n, in_take, r_state == S_PREP)
    `SEGR_ASSERT_IMP(a_gain_in_range, i_clk, i_rst_n, o_out_valid, o_gain <= GAIN_OUT_UNITY)
    `SEGR_ASSERT_IMP(a_ramp_keeps_active, i_clk, i_rst_n, o_out_valid && (o_ramp_left != '0), o_active)
    `SEGR_ASSERT_IMP(a_idle_step_cleared, i_clk, i_rst_n, (r_state == S_IDLE) && (r_rem == '0), r_step_mag == '0)

endmodule

`default_nettype wire
